FILE: rtl/b2rds_pkg.sv
// Package for the binary to radix digit stream block.
// Holds the mode codes, controller states, command/status structs and the ASCII map.
// No dependencies.
`timescale 1ns / 1ps

package b2rds_pkg;

    typedef enum logic [1:0] {
        FUNC_BIN   = 2'd0,
        FUNC_OCT   = 2'd1,
        FUNC_HEX   = 2'd2,
        FUNC_WORDS = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic emit_last;
    } status_t;

    localparam logic [6:0] ASCII_ZERO = 7'd48;
    localparam logic [6:0] ASCII_A    = 7'd65;

    function automatic logic [6:0] ascii_of_digit(input logic [3:0] d);
        logic [6:0] c;
        if (d > 4'd9)
        begin
            c = ASCII_A + {3'b000, d} - 7'd10;
        end
        else
        begin
            c = ASCII_ZERO + {3'b000, d};
        end
        return c;
    endfunction

endpackage

FILE: rtl/b2rds_ctrl.sv
// Controller for the digit stream: load, conversion pass, emission pass.
// Depends on b2rds_pkg.
`timescale 1ns / 1ps

module b2rds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  b2rds_pkg::status_t status,
    output b2rds_pkg::cmd_t    cmd,
    output logic               busy
);

    b2rds_pkg::state_t state_reg;
    b2rds_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2rds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b2rds_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = b2rds_pkg::ST_CONVERT;
                end
            end
            b2rds_pkg::ST_CONVERT:
            begin
                if (status.conv_last)
                begin
                    state_next = b2rds_pkg::ST_EMIT;
                end
            end
            b2rds_pkg::ST_EMIT:
            begin
                if (status.emit_last)
                begin
                    state_next = b2rds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = b2rds_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            b2rds_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            b2rds_pkg::ST_CONVERT:
            begin
                cmd.conv_step = 1'b1;
            end
            b2rds_pkg::ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/b2rds_dp.sv
// Datapath: digit register, shift or double-dabble conversion, emission shifter.
// Depends on b2rds_pkg.
`timescale 1ns / 1ps

module b2rds_dp #(
    parameter int VALUE_BITS  = 31,
    parameter int DIGIT_SLOTS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b2rds_pkg::cmd_t       cmd,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [1:0]            func,
    output b2rds_pkg::status_t    status,
    output logic                  strobe,
    output logic [3:0]            digit,
    output logic [6:0]            ascii_char,
    output logic                  spell_word,
    output logic                  last
);

    localparam int DW       = 4 * DIGIT_SLOTS;
    localparam int STEP_MAX = (VALUE_BITS > DIGIT_SLOTS) ? VALUE_BITS : DIGIT_SLOTS;
    localparam int SW       = $clog2(STEP_MAX);
    localparam int CW       = $clog2(DIGIT_SLOTS + 1);
    localparam int MW       = (SW > CW) ? SW : CW;
    localparam logic [CW-1:0] SLOTS_C = CW'(DIGIT_SLOTS);

    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [DW-1:0]         dig_reg, dig_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [CW-1:0]         count_reg, count_next;
    b2rds_pkg::func_t      func_reg, func_next;
    logic                  started_reg, started_next;
    logic                  strobe_reg, strobe_next;
    logic [3:0]            digit_reg;
    logic [6:0]            ascii_reg;
    logic                  spell_reg;
    logic                  last_reg;

    logic [DW-1:0] dig_adj;
    logic [3:0]    low_nib;
    logic [3:0]    top_nib;
    logic          is_words;
    logic          emit_now;

    assign is_words = (func_reg == b2rds_pkg::FUNC_WORDS);
    assign top_nib  = dig_reg[DW-1 -: 4];

    // add-3 correction on every BCD digit ahead of the shift
    always_comb
    begin
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
            begin
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        unique case (func_reg)
            b2rds_pkg::FUNC_BIN: low_nib = {3'b000, num_reg[0]};
            b2rds_pkg::FUNC_OCT: low_nib = {1'b0, num_reg[2:0]};
            default:             low_nib = num_reg[3:0];
        endcase
    end

    always_comb
    begin
        if (is_words)
        begin
            emit_now = started_reg || (top_nib != 4'd0);
        end
        else
        begin
            emit_now = (MW'(step_reg) < MW'(count_reg));
        end
    end

    always_comb
    begin
        num_next     = num_reg;
        dig_next     = dig_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        func_next    = func_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        if (cmd.load)
        begin
            num_next     = value;
            dig_next     = '0;
            count_next   = '0;
            started_next = 1'b0;
            func_next    = b2rds_pkg::func_t'(func);
            if (b2rds_pkg::func_t'(func) == b2rds_pkg::FUNC_WORDS)
            begin
                step_next = SW'(VALUE_BITS - 1);
            end
            else
            begin
                step_next = SW'(DIGIT_SLOTS - 1);
            end
        end
        else if (cmd.conv_step)
        begin
            if (is_words)
            begin
                dig_next = {dig_adj[DW-2:0], num_reg[VALUE_BITS-1]};
                num_next = {num_reg[VALUE_BITS-2:0], 1'b0};
            end
            else
            begin
                dig_next = {low_nib, dig_reg[DW-1:4]};
                unique case (func_reg)
                    b2rds_pkg::FUNC_BIN: num_next = num_reg >> 1;
                    b2rds_pkg::FUNC_OCT: num_next = num_reg >> 3;
                    default:             num_next = num_reg >> 4;
                endcase
                if ((num_reg != '0) && (count_reg < SLOTS_C))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            if (step_reg == '0)
            begin
                step_next = SW'(DIGIT_SLOTS - 1);
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
        else if (cmd.emit_step)
        begin
            dig_next    = {dig_reg[DW-5:0], 4'b0000};
            step_next   = step_reg - 1'b1;
            strobe_next = emit_now;
            if (emit_now)
            begin
                started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        dig_reg     <= dig_next;
        step_reg    <= step_next;
        count_reg   <= count_next;
        func_reg    <= func_next;
        started_reg <= started_next;
        if (cmd.emit_step)
        begin
            digit_reg <= top_nib;
            ascii_reg <= b2rds_pkg::ascii_of_digit(top_nib);
            spell_reg <= is_words;
            last_reg  <= (step_reg == '0);
        end
    end

    assign status.conv_last = cmd.conv_step && (step_reg == '0);
    assign status.emit_last = cmd.emit_step && (step_reg == '0);

    assign strobe     = strobe_reg;
    assign digit      = digit_reg;
    assign ascii_char = ascii_reg;
    assign spell_word = spell_reg;
    assign last       = last_reg;

endmodule

FILE: rtl/binary_to_radix_digit_stream.sv
// Top level of the binary to radix digit stream block.
// Depends on b2rds_pkg, b2rds_ctrl and b2rds_dp.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Digits come out most
// significant first, one per strobe, with last on the final digit; the
// receiver cannot stall, so each result is valid for exactly one cycle. A
// zero value gives no strobes. In decimal word mode a request runs a
// double-dabble pass of one bit per cycle, then an emission pass of one
// digit slot per cycle; in binary, octal and hexadecimal both passes run
// at one digit slot per cycle. Busy drops on the cycle the last digit is
// shown, so the next request may be taken while that digit is still on
// the ports.

module binary_to_radix_digit_stream #(
    parameter int VALUE_BITS  = 31,
    parameter int DIGIT_SLOTS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [1:0]            func,
    output logic                  strobe,
    output logic [3:0]            digit,
    output logic [6:0]            ascii_char,
    output logic                  spell_word,
    output logic                  last
);

    b2rds_pkg::cmd_t    cmd;
    b2rds_pkg::status_t status;

    b2rds_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    b2rds_dp #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .func       (func),
        .status     (status),
        .strobe     (strobe),
        .digit      (digit),
        .ascii_char (ascii_char),
        .spell_word (spell_word),
        .last       (last)
    );

`ifndef NO_ASSERTIONS
    a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result strobe without an active request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("strobe directly after final digit");

    a_ascii_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((ascii_char >= 7'd48 && ascii_char <= 7'd57) ||
                    (ascii_char >= 7'd65 && ascii_char <= 7'd70)))
        else $error("ascii character out of range");
`endif

endmodule
